### rtl/dsld_pkg.sv
package dsld_pkg;

  localparam int SYMBOLS_DEF = 4096;
  localparam int LEVELS_DEF  = 5;

  localparam int SYM_W   = 12;
  localparam int LVLIN_W = 3;
  localparam int PX_W    = 32;
  localparam int QTY_W   = 31;
  localparam int TONE_W  = 8;
  localparam int STAMP_W = 28;

  // Tone character that marks a snapshot to be dropped.
  localparam logic [TONE_W-1:0] TONE_P = 8'h50;

  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [QTY_W-1:0] qty;
  } lvl_t;

  typedef struct packed {
    logic             side;
    logic [PX_W-1:0]  px;
    logic [QTY_W-1:0] qty;
  } delta_t;

endpackage

### rtl/dsld_book.sv
module dsld_book #(
  parameter int DEPTH = 40960
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output dsld_pkg::lvl_t           rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  dsld_pkg::lvl_t           wr_data,
  output logic                     ready
);
  import dsld_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  lvl_t              mem [DEPTH];
  lvl_t              rd_q_r;
  logic              clr_active_r;
  logic              clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  lvl_t              wdata;

  // After reset the sweep writes zero to every entry, one per cycle.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  assign we    = clr_active_r | wr_en;
  assign waddr = clr_active_r ? clr_addr_r : wr_addr;
  assign wdata = clr_active_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;
  assign ready   = ~clr_active_r;

endmodule

### rtl/dsld_shadow.sv
module dsld_shadow #(
  parameter int SLOTS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_slot,
  input  dsld_pkg::lvl_t                        wr_data,
  input  logic                                  clr,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  output dsld_pkg::lvl_t                        rd_data,
  output logic                                  rd_valid
);
  import dsld_pkg::*;

  lvl_t             entry_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_slot] = 1'b1;
    end
    // Closing a snapshot wins over the write of its last item.
    if (clr) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_slot] <= wr_data;
    end
  end

  assign rd_data  = entry_r[rd_slot];
  assign rd_valid = valid_r[rd_slot];

endmodule

### rtl/depth_snapshot_to_level_deltas.sv
// An item with a level below LEVELS is stored in its shadow slot. A closing item that is
// not dropped (drop tone, zero stamp, symbol out of range) starts a scan of 2*LEVELS levels:
// each is read in S_READ, a stored one is compared with the book in S_CMP, and a price change
// over a nonzero old price adds S_PUSH; the deltas then strobe one per cycle out of S_DRAIN.
// Throughput: one open item per cycle while busy is low; busy stays high through a scan and
// its drain. Reset (rst_n low, synchronous) clears control state, then all SYMBOLS*2*LEVELS
// store entries are zeroed with busy high. Results cannot be stalled by the receiver.
module depth_snapshot_to_level_deltas #(
  parameter int SYMBOLS = dsld_pkg::SYMBOLS_DEF,
  parameter int LEVELS  = dsld_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dsld_pkg::SYM_W-1:0]   in_symbol_id,
  input  logic                         in_side,
  input  logic [dsld_pkg::LVLIN_W-1:0] in_level,
  input  logic [dsld_pkg::PX_W-1:0]    in_price,
  input  logic [dsld_pkg::QTY_W-1:0]   in_quantity,
  input  logic [dsld_pkg::TONE_W-1:0]  in_ask_tone,
  input  logic [dsld_pkg::TONE_W-1:0]  in_bid_tone,
  input  logic [dsld_pkg::STAMP_W-1:0] in_stamp,
  input  logic                         in_snapshot_end,
  output logic                         out_valid,
  output logic [dsld_pkg::SYM_W-1:0]   out_symbol,
  output logic                         out_side,
  output logic [dsld_pkg::PX_W-1:0]    out_price,
  output logic [dsld_pkg::QTY_W-1:0]   out_quantity,
  output logic [dsld_pkg::STAMP_W-1:0] out_stamp,
  output logic [dsld_pkg::TONE_W-1:0]  out_ask_tone,
  output logic [dsld_pkg::TONE_W-1:0]  out_bid_tone,
  output logic                         out_last_of_group
);
  import dsld_pkg::*;

  localparam int SLOTS  = 2 * LEVELS;
  localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int LVL_W  = LEVELS > 1 ? $clog2(LEVELS) : 1;
  localparam int DEPTH  = SYMBOLS * 2 * LEVELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PEND_N = 2 * SLOTS;
  localparam int IDX_W  = $clog2(PEND_N);
  localparam int CNT_W  = $clog2(PEND_N + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_PUSH  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic               scan_side_r, scan_side_nxt;
  logic [LVL_W-1:0]   scan_lvl_r, scan_lvl_nxt;
  logic [CNT_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [CNT_W-1:0]   drain_k_r, drain_k_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  delta_t             pend_r [PEND_N];

  logic [SYM_W-1:0]   sym_r;
  logic [TONE_W-1:0]  atone_r;
  logic [TONE_W-1:0]  btone_r;
  logic [STAMP_W-1:0] stamp_r;

  logic               out_valid_r, out_valid_nxt;
  delta_t             out_delta_r;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               level_ok;
  logic               drop;
  logic               book_ready;
  lvl_t               book_rd;
  logic               book_we;
  lvl_t               new_lvl;
  lvl_t               in_lvl;
  logic               sh_valid;
  logic               sh_clr;
  logic [SLOT_W-1:0]  in_slot;
  logic [SLOT_W-1:0]  scan_slot;
  logic               scan_last;
  logic               push_en;
  delta_t             push_data;

  assign accept    = start & ~busy;
  assign level_ok  = 32'(in_level) < LEVELS;
  assign drop      = (in_ask_tone == TONE_P) || (in_bid_tone == TONE_P) ||
                     (in_stamp == '0) || (32'(in_symbol_id) >= SYMBOLS);
  assign in_slot   = SLOT_W'(32'(in_side) * LEVELS + 32'(in_level));
  assign scan_slot = SLOT_W'(32'(scan_side_r) * LEVELS + 32'(scan_lvl_r));
  assign scan_last = scan_side_r && (scan_lvl_r == LVL_W'(LEVELS - 1));
  assign in_lvl    = '{px: in_price, qty: in_quantity};

  dsld_shadow #(
    .SLOTS(SLOTS)
  ) u_shadow (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept & level_ok),
    .wr_slot (in_slot),
    .wr_data (in_lvl),
    .clr     (sh_clr),
    .rd_slot (scan_slot),
    .rd_data (new_lvl),
    .rd_valid(sh_valid)
  );

  dsld_book #(
    .DEPTH(DEPTH)
  ) u_book (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(idx_nxt),
    .rd_data(book_rd),
    .wr_en  (book_we),
    .wr_addr(idx_r),
    .wr_data(new_lvl),
    .ready  (book_ready)
  );

  assign busy = (state_r != S_IDLE) || !book_ready;

  always_comb begin
    state_nxt     = state_r;
    scan_side_nxt = scan_side_r;
    scan_lvl_nxt  = scan_lvl_r;
    pend_cnt_nxt  = pend_cnt_r;
    drain_k_nxt   = drain_k_r;
    idx_nxt       = idx_r;
    sh_clr        = 1'b0;
    book_we       = 1'b0;
    push_en       = 1'b0;
    push_data     = '{side: scan_side_r, px: new_lvl.px, qty: new_lvl.qty};
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_snapshot_end) begin
          pend_cnt_nxt  = '0;
          drain_k_nxt   = '0;
          scan_side_nxt = 1'b0;
          scan_lvl_nxt  = '0;
          if (drop) begin
            sh_clr = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        idx_nxt = ADDR_W'((32'(sym_r) * 2 + 32'(scan_side_r)) * LEVELS + 32'(scan_lvl_r));
        if (sh_valid && (new_lvl.px != '0)) begin
          state_nxt = S_CMP;
        end else if (scan_last) begin
          state_nxt = S_DRAIN;
          sh_clr    = 1'b1;
        end else if (scan_lvl_r == LVL_W'(LEVELS - 1)) begin
          scan_side_nxt = 1'b1;
          scan_lvl_nxt  = '0;
        end else begin
          scan_lvl_nxt = scan_lvl_r + LVL_W'(1);
        end
      end
      S_CMP, S_PUSH: begin
        if (state_r == S_CMP) begin
          book_we = 1'b1;
          if (new_lvl.px != book_rd.px) begin
            push_en = 1'b1;
            if (book_rd.px != '0) begin
              push_data = '{side: scan_side_r, px: book_rd.px, qty: '0};
            end
          end else if (new_lvl.qty != book_rd.qty) begin
            push_en = 1'b1;
          end
        end else begin
          push_en = 1'b1;
        end
        // A price change over a nonzero old price needs a second push for the new level.
        if (state_r == S_CMP && new_lvl.px != book_rd.px && book_rd.px != '0) begin
          state_nxt = S_PUSH;
        end else if (scan_last) begin
          state_nxt = S_DRAIN;
          sh_clr    = 1'b1;
        end else begin
          state_nxt = S_READ;
          if (scan_lvl_r == LVL_W'(LEVELS - 1)) begin
            scan_side_nxt = 1'b1;
            scan_lvl_nxt  = '0;
          end else begin
            scan_lvl_nxt = scan_lvl_r + LVL_W'(1);
          end
        end
        if (push_en) begin
          pend_cnt_nxt = pend_cnt_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (drain_k_r == pend_cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (drain_k_r + CNT_W'(1)) == pend_cnt_r;
          drain_k_nxt   = drain_k_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_side_r <= 1'b0;
      scan_lvl_r  <= '0;
      pend_cnt_r  <= '0;
      drain_k_r   <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_side_r <= scan_side_nxt;
      scan_lvl_r  <= scan_lvl_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      drain_k_r   <= drain_k_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (push_en) begin
      pend_r[pend_cnt_r[IDX_W-1:0]] <= push_data;
    end
    if (accept && in_snapshot_end) begin
      sym_r   <= in_symbol_id;
      atone_r <= in_ask_tone;
      btone_r <= in_bid_tone;
      stamp_r <= in_stamp;
    end
    if (out_valid_nxt) begin
      out_delta_r <= pend_r[drain_k_r[IDX_W-1:0]];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = sym_r;
  assign out_side          = out_delta_r.side;
  assign out_price         = out_delta_r.px;
  assign out_quantity      = out_delta_r.qty;
  assign out_stamp         = stamp_r;
  assign out_ask_tone      = atone_r;
  assign out_bid_tone      = btone_r;
  assign out_last_of_group = out_last_r;

  // A delta strobe only follows a drain cycle.
  a_strobe_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DRAIN))
    else $error("delta strobe outside drain");

  // The last mark never stands without a strobe.
  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last mark without delta");

  // No transaction is taken while the store is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !book_ready |-> busy)
    else $error("accept during store clearing");

  // Each level adds at most two deltas, so the buffer cannot overflow.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= CNT_W'(PEND_N))
    else $error("delta buffer overflow");

  // The drain pointer never runs past the buffered count.
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (drain_k_r <= pend_cnt_r))
    else $error("drain pointer past count");

endmodule
